>>> rtl/cose_pkg.sv
`timescale 1ns / 1ps

package cose_pkg;

   localparam int SAMPLE_TIME = 1;

   localparam int SAT_LIMIT   = 17179869;
   localparam int SCALE_MUL   = 125;
   localparam int SCALE_SHIFT = 14;
   localparam int SCALE_BIAS  = (1 << SCALE_SHIFT) - 1;
   localparam int CAP_MUL     = 5;
   localparam int CAP_ROUND   = 16;
   localparam int CAP_SHIFT   = 5;
   localparam int DIV10_MUL   = 52429;
   localparam int DIV10_SHIFT = 19;
   localparam int STOP_LIMIT  = 5000;
   localparam int MASS_MAX    = 65535;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [2:0] REG_LOW_SET      = 3'd0;
   localparam logic [2:0] REG_LOW_RELEASE  = 3'd1;
   localparam logic [2:0] REG_HIGH_SET     = 3'd2;
   localparam logic [2:0] REG_HIGH_RELEASE = 3'd3;
   localparam logic [2:0] REG_FLOW_FACTORS = 3'd4;
   localparam logic [2:0] REG_STALL_OFFSET = 3'd5;
   localparam logic [2:0] REG_INIT_CAP     = 3'd6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CAP,
      S_FLOW,
      S_TIME,
      S_SCALE,
      S_UPDATE,
      S_DIV,
      S_DONE
   } state_type;

endpackage

>>> rtl/catalyst_oxygen_store_estimator.sv
`timescale 1ns / 1ps

// Catalyst oxygen-store estimator. One request word per sample tick; each word
// steps from idle through S_CAP to S_DONE, as the single shared 34x18 multiplier
// handles in turn the capacity scale, factor*flow (or stall offset*5), the
// sample-time product, the 125/16384 scaling and the divide by ten. The response
// word is registered and becomes valid as the word leaves S_DONE. req_stall is
// high while a word is in work; a finished word waits in its last step while
// the previous response word has not been taken, and the response fields are
// held in output registers until taken. Configuration writes are accepted only
// while no word is in work.
module catalyst_oxygen_store_estimator (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_upstream_heat_ok,
   input  logic        req_downstream_heat_ok,
   input  logic        req_engine_running,
   input  logic        req_upstream_rich,
   input  logic        req_downstream_rich,
   input  logic [15:0] req_exhaust_flow,
   input  logic [15:0] req_probe_voltage,
   input  logic [15:0] req_capacity_estimate,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [12:0] rsp_stored_now,
   output logic [12:0] rsp_stop_mass,
   output logic [15:0] rsp_restart_mass,
   output logic        rsp_low_flag,
   output logic        rsp_high_flag,
   output logic [15:0] rsp_normal_estimate,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   cose_pkg::state_type state_ff, state_in;

   logic [15:0] low_set_ff, low_rel_ff, high_set_ff, high_rel_ff;
   logic [31:0] factors_ff;
   logic [15:0] stall_off_ff;

   logic        heat_ff, run_ff, up_rich_ff, dn_rich_ff;
   logic [15:0] flow_ff, volt_ff, cap_ff;

   logic signed [cose_pkg::PROD_W-1:0] p_ff, p_in;
   logic [13:0] lim_ff, lim_in;
   logic        sat_hi_ff, sat_hi_in, sat_lo_ff, sat_lo_in;

   logic [15:0] norm_ff, norm_in;
   logic [15:0] err_ff, err_in;
   logic        low_ff, low_in, high_ff, high_in;
   logic [15:0] last_volt_ff, last_volt_in;
   logic        was_run_ff, was_run_in;
   logic [12:0] stop_ff, stop_in;
   logic [15:0] restart_ff, restart_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] out_stored_ff;
   logic        out_low_ff, out_high_ff;
   logic [15:0] out_norm_ff;
   logic        out_load;

   logic signed [cose_pkg::MUL_A_W-1:0] mul_a;
   logic signed [cose_pkg::MUL_B_W-1:0] mul_b;
   logic signed [cose_pkg::PROD_W-1:0]  mul_p;

   logic [1:0]                          fac_idx;
   logic signed [7:0]                   fac;
   logic signed [cose_pkg::PROD_W-1:0]  biased;
   logic signed [cose_pkg::PROD_W-1:0]  quot;
   logic signed [18:0]                  sum;
   logic signed [22:0]                  diff;
   logic                                low_set_hit, high_set_hit;
   logic [15:0]                         sel;
   logic [12:0]                         stored;
   logic [16:0]                         times_ten;
   logic [19:0]                         init_scaled;
   logic                                accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != cose_pkg::S_IDLE);
   assign csr_ready = (state_ff == cose_pkg::S_IDLE);

   assign fac_idx = {~dn_rich_ff, ~up_rich_ff};
   assign fac     = factors_ff[{fac_idx, 3'b000} +: 8];

   assign mul_p = mul_a * mul_b;

   assign init_scaled = ({4'd0, csr_data[15:0]} << 2) + {4'd0, csr_data[15:0]};

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      lim_in       = lim_ff;
      sat_hi_in    = sat_hi_ff;
      sat_lo_in    = sat_lo_ff;
      norm_in      = norm_ff;
      err_in       = err_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      last_volt_in = last_volt_ff;
      was_run_in   = was_run_ff;
      stop_in      = stop_ff;
      restart_in   = restart_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_load     = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      biased = p_ff + ((p_ff < 0) ? cose_pkg::PROD_W'(cose_pkg::SCALE_BIAS) : '0);
      quot   = biased >>> cose_pkg::SCALE_SHIFT;
      sum    = $signed({3'b000, norm_ff}) + $signed(quot[18:0]);
      diff   = $signed({2'b00, norm_ff, 5'b00000}) - $signed(p_ff[22:0]);

      low_set_hit  = (volt_ff <= low_set_ff) && (last_volt_ff > low_set_ff);
      high_set_hit = (volt_ff >= high_set_ff) && (last_volt_ff < high_set_ff);

      sel = (low_ff || high_ff) ? err_ff : norm_ff;
      if (sel >= {2'b00, lim_ff}) begin
         sel = {2'b00, lim_ff};
      end
      stored    = p_ff[cose_pkg::DIV10_SHIFT +: 13];
      times_ten = ({4'd0, stored} << 3) + ({4'd0, stored} << 1);

      unique case (state_ff)
         cose_pkg::S_IDLE: begin
            if (accept) begin
               state_in = cose_pkg::S_CAP;
            end
         end
         cose_pkg::S_CAP: begin
            mul_a    = $signed({18'd0, cap_ff});
            mul_b    = cose_pkg::MUL_B_W'(cose_pkg::CAP_MUL);
            p_in     = mul_p;
            state_in = cose_pkg::S_FLOW;
         end
         cose_pkg::S_FLOW: begin
            lim_in = 14'((p_ff[19:0] + 20'(cose_pkg::CAP_ROUND)) >> cose_pkg::CAP_SHIFT);
            if (run_ff) begin
               mul_a = $signed({18'd0, flow_ff});
               mul_b = {{(cose_pkg::MUL_B_W - 8){fac[7]}}, fac};
            end else begin
               mul_a = $signed({18'd0, stall_off_ff});
               mul_b = cose_pkg::MUL_B_W'(cose_pkg::CAP_MUL);
            end
            p_in     = mul_p;
            state_in = cose_pkg::S_TIME;
         end
         cose_pkg::S_TIME: begin
            mul_a    = p_ff[cose_pkg::MUL_A_W-1:0];
            mul_b    = run_ff ? cose_pkg::MUL_B_W'(cose_pkg::SAMPLE_TIME)
                              : cose_pkg::MUL_B_W'(1);
            p_in     = mul_p;
            state_in = cose_pkg::S_SCALE;
         end
         cose_pkg::S_SCALE: begin
            sat_hi_in = (p_ff >= cose_pkg::PROD_W'(cose_pkg::SAT_LIMIT));
            sat_lo_in = (p_ff <= -cose_pkg::PROD_W'(cose_pkg::SAT_LIMIT));
            mul_a     = p_ff[cose_pkg::MUL_A_W-1:0];
            mul_b     = run_ff ? cose_pkg::MUL_B_W'(cose_pkg::SCALE_MUL)
                               : cose_pkg::MUL_B_W'(1);
            p_in      = mul_p;
            state_in  = cose_pkg::S_UPDATE;
         end
         cose_pkg::S_UPDATE: begin
            if (heat_ff) begin
               if (run_ff) begin
                  priority if (sat_hi_ff) begin
                     norm_in = 16'(cose_pkg::MASS_MAX);
                  end else if (sat_lo_ff) begin
                     norm_in = '0;
                  end else if (sum < 0) begin
                     norm_in = '0;
                  end else if (sum > 19'sd65535) begin
                     norm_in = 16'(cose_pkg::MASS_MAX);
                  end else begin
                     norm_in = sum[15:0];
                  end
               end else begin
                  norm_in = (diff < 0) ? '0 : diff[20:5];
               end
               priority if (volt_ff > high_set_ff) begin
                  err_in = '0;
               end else if (volt_ff <= low_set_ff) begin
                  err_in = {2'b00, lim_ff};
               end else begin
                  err_in = err_ff;
               end
            end
            low_in  = (low_ff || low_set_hit) &&
                      !((volt_ff >= low_rel_ff) && (!low_ff || last_volt_ff < low_rel_ff));
            high_in = (high_ff || high_set_hit) &&
                      !((volt_ff <= high_rel_ff) && (!high_ff || last_volt_ff > high_rel_ff));
            last_volt_in = volt_ff;
            state_in     = cose_pkg::S_DIV;
         end
         cose_pkg::S_DIV: begin
            mul_a    = $signed({18'd0, sel});
            mul_b    = cose_pkg::MUL_B_W'(cose_pkg::DIV10_MUL);
            p_in     = mul_p;
            state_in = cose_pkg::S_DONE;
         end
         cose_pkg::S_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (run_ff && !was_run_ff) begin
                  stop_in    = (stored > 13'(cose_pkg::STOP_LIMIT)) ?
                               13'(cose_pkg::STOP_LIMIT) : stored;
                  restart_in = (times_ten > 17'(cose_pkg::MASS_MAX)) ?
                               16'(cose_pkg::MASS_MAX) : times_ten[15:0];
               end
               was_run_in   = run_ff;
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = cose_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cose_pkg::S_IDLE;
         end
      endcase

      // start value loads the estimate
      if (csr_valid && csr_ready && (csr_index == cose_pkg::REG_INIT_CAP)) begin
         norm_in = {1'b0, init_scaled[19:cose_pkg::CAP_SHIFT]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cose_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         low_set_ff   <= '0;
         low_rel_ff   <= '0;
         high_set_ff  <= 16'(cose_pkg::MASS_MAX);
         high_rel_ff  <= 16'(cose_pkg::MASS_MAX);
         factors_ff   <= '0;
         stall_off_ff <= '0;
         norm_ff      <= '0;
         err_ff       <= '0;
         low_ff       <= 1'b0;
         high_ff      <= 1'b0;
         last_volt_ff <= '0;
         was_run_ff   <= 1'b0;
         stop_ff      <= '0;
         restart_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         norm_ff      <= norm_in;
         err_ff       <= err_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         last_volt_ff <= last_volt_in;
         was_run_ff   <= was_run_in;
         stop_ff      <= stop_in;
         restart_ff   <= restart_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cose_pkg::REG_LOW_SET:      low_set_ff   <= csr_data[15:0];
               cose_pkg::REG_LOW_RELEASE:  low_rel_ff   <= csr_data[15:0];
               cose_pkg::REG_HIGH_SET:     high_set_ff  <= csr_data[15:0];
               cose_pkg::REG_HIGH_RELEASE: high_rel_ff  <= csr_data[15:0];
               cose_pkg::REG_FLOW_FACTORS: factors_ff   <= csr_data;
               cose_pkg::REG_STALL_OFFSET: stall_off_ff <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      lim_ff    <= lim_in;
      sat_hi_ff <= sat_hi_in;
      sat_lo_ff <= sat_lo_in;
      if (accept) begin
         heat_ff    <= req_upstream_heat_ok && req_downstream_heat_ok;
         run_ff     <= req_engine_running;
         up_rich_ff <= req_upstream_rich;
         dn_rich_ff <= req_downstream_rich;
         flow_ff    <= req_exhaust_flow;
         volt_ff    <= req_probe_voltage;
         cap_ff     <= req_capacity_estimate;
      end
      if (out_load) begin
         out_stored_ff <= stored;
         out_low_ff    <= low_ff;
         out_high_ff   <= high_ff;
         out_norm_ff   <= norm_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stored_now      = out_stored_ff;
   assign rsp_stop_mass       = stop_ff;
   assign rsp_restart_mass    = restart_ff;
   assign rsp_low_flag        = out_low_ff;
   assign rsp_high_flag       = out_high_ff;
   assign rsp_normal_estimate = out_norm_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == cose_pkg::S_CAP)
      else $error("accepted word did not start the sequencer");

   a_done_delivers : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cose_pkg::S_DONE && !(rsp_valid_ff && rsp_stall)) |=>
      (rsp_valid_ff && state_ff == cose_pkg::S_IDLE))
      else $error("finished word not presented");

   a_stop_limit : assert property (@(posedge clock) disable iff (reset)
      stop_ff <= 13'(cose_pkg::STOP_LIMIT))
      else $error("stop mass above limit");

   a_stall_no_rise : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cose_pkg::S_UPDATE && heat_ff && !run_ff) |=>
      norm_ff <= $past(norm_ff))
      else $error("stalled update raised the estimate");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
      (rsp_valid_ff && $stable(out_norm_ff) && $stable(out_stored_ff) &&
       $stable(stop_ff)))
      else $error("stalled response word changed");
`endif

endmodule
